// ===== design/assert_macros.svh =====
// concurrent assertion helpers, sampled on clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_AT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== design/pcrq_pkg.sv =====
package pcrq_pkg;

	localparam int FIELD_W = 16;
	localparam int OCC_W   = 5;
	localparam int ACT_W   = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_POST = 2'd0,
		ACT_PRIO = 2'd1,
		ACT_TAKE = 2'd2
	} action_t;

	typedef struct packed {
		logic             taken;
		logic             overflow;
		logic [OCC_W-1:0] occupancy;
	} res_t;

endpackage

// ===== design/pcrq_ram.sv =====
module pcrq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/pcrq_ctrl.sv =====
`include "assert_macros.svh"

module pcrq_ctrl #(
	parameter int QUEUE_DEPTH = 16,
	localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        acc,
	input  logic [pcrq_pkg::ACT_W-1:0]  action,
	output logic                        wr_en,
	output logic [IDX_W-1:0]            wr_addr,
	output logic                        rd_en,
	output logic [IDX_W-1:0]            rd_addr,
	output pcrq_pkg::res_t              res
);

	import pcrq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	logic [IDX_W-1:0] front_q, back_q, front_d, back_d;
	logic [IDX_W-1:0] front_inc, front_dec, back_inc;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             full, empty;

	assign full      = (cnt_q == FULL_CNT);
	assign empty     = (cnt_q == '0);
	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
	assign back_inc  = (back_q == LAST_IDX) ? '0 : back_q + 1'b1;

	always_comb begin
		front_d      = front_q;
		back_d       = back_q;
		cnt_d        = cnt_q;
		wr_en        = 1'b0;
		wr_addr      = back_q;
		rd_en        = 1'b0;
		rd_addr      = front_q;
		res.taken    = 1'b0;
		res.overflow = 1'b0;
		case (action)
			ACT_POST: begin
				if (full) begin
					res.overflow = 1'b1;
				end else begin
					wr_en  = acc;
					back_d = back_inc;
					cnt_d  = cnt_q + 1'b1;
				end
			end
			ACT_PRIO: begin
				if (full) begin
					res.overflow = 1'b1;
				end else begin
					wr_en   = acc;
					wr_addr = front_dec;
					front_d = front_dec;
					cnt_d   = cnt_q + 1'b1;
				end
			end
			ACT_TAKE: begin
				if (!empty) begin
					rd_en     = acc;
					res.taken = 1'b1;
					front_d   = front_inc;
					cnt_d     = cnt_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
		res.occupancy = OCC_W'(cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			cnt_q   <= '0;
		end else if (acc) begin
			front_q <= front_d;
			back_q  <= back_d;
			cnt_q   <= cnt_d;
		end
	end

	`ASSERT_NEVER(a_cnt_bound, cnt_q > FULL_CNT, "entry count above queue depth")
	`ASSERT_AT(a_ends_meet, (empty || full) |-> (front_q == back_q),
		"indices apart while queue empty or full")
	`ASSERT_NEVER(a_rw_excl, wr_en && rd_en, "read and write from one item")

endmodule

// ===== design/priority_call_ring_queue_unit.sv =====
// channel  dir  tdata (low bit up)                        tuser
// s_*      in   handler_id[15:0] param_value[31:16]        action[1:0]
// m_*      out  out_handler[15:0] out_param[31:16]         taken
//               occupancy[36:32] overflow[37]
// one item accepted per cycle while s_tready is high; indices and count
// update in the accept cycle, the entry memory read lands in the next cycle
// and the result is then held in the output register
// reset clears indices, count and valid flags; entry memory is not cleared
// output stall holds the read stage, and input ready drops once both are full
`include "assert_macros.svh"

module priority_call_ring_queue_unit #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int HANDLER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // handler_id, param_value
	input  logic [1:0]  s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // out_handler, out_param, occupancy, overflow
	output logic        m_tuser    // taken
);

	import pcrq_pkg::*;

	localparam int HID_W = (HANDLER_BITS < FIELD_W) ? HANDLER_BITS : FIELD_W;
	localparam int ENT_W = HID_W + FIELD_W;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	logic             acc, adv;
	logic             wr_en, rd_en;
	logic [IDX_W-1:0] wr_addr, rd_addr;
	logic [ENT_W-1:0] wr_data, rd_data;
	res_t             res;

	logic             valid_s1;
	res_t             res_s1;

	logic               out_valid_q;
	logic               out_taken_q;
	logic               out_ovf_q;
	logic [FIELD_W-1:0] out_handler_q, out_param_q;
	logic [OCC_W-1:0]   out_occ_q;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign acc      = s_tvalid && s_tready;
	assign wr_data  = {s_tdata[2*FIELD_W-1:FIELD_W], s_tdata[HID_W-1:0]};

	pcrq_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.action (s_tuser),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.res    (res)
	);

	pcrq_ram #(
		.WIDTH(ENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= acc || (valid_s1 && !adv);
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res;
		end
		if (adv && valid_s1) begin
			out_taken_q   <= res_s1.taken;
			out_ovf_q     <= res_s1.overflow;
			out_occ_q     <= res_s1.occupancy;
			out_handler_q <= res_s1.taken ? FIELD_W'(rd_data[HID_W-1:0]) : '0;
			out_param_q   <= res_s1.taken ? rd_data[ENT_W-1:HID_W] : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_taken_q;
	assign m_tdata  = {2'b00, out_ovf_q, out_occ_q, out_param_q, out_handler_q};

	`ASSERT_AT(a_acc_s1, acc |=> valid_s1, "accepted item missing from read stage")
	`ASSERT_AT(a_s1_hold, (valid_s1 && !adv) |=> (valid_s1 && $stable(res_s1)),
		"stalled read stage changed")
	`ASSERT_NEVER(a_take_ovf, out_valid_q && out_taken_q && out_ovf_q,
		"result both taken and overflow")

endmodule

// ===== test/testbench.sv =====
module testbench;
	import pcrq_pkg::*;

	localparam int DEPTH = 16;
	localparam int SLOT_W = 4;
	localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic               taken;
		logic [FIELD_W-1:0] handler;
		logic [FIELD_W-1:0] param;
		logic [OCC_W-1:0]   occupancy;
		logic               overflow;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tuser;

	logic [FIELD_W-1:0] handler_slots [DEPTH];
	logic [FIELD_W-1:0] param_slots [DEPTH];
	logic [SLOT_W-1:0]  back_slot = '0;
	logic [SLOT_W-1:0]  front_slot = '0;
	logic [OCC_W-1:0]   held_calls = '0;
	reply_t             expected_replies [$];

	int          failures = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int unsigned cycle_count = 0;

	priority_call_ring_queue_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic reply_t serve_call_action(input logic [ACT_W-1:0] act,
			input logic [FIELD_W-1:0] hid, input logic [FIELD_W-1:0] pval);
		reply_t rep;
		rep = '0;
		if (act == ACT_POST || act == ACT_PRIO) begin
			if (held_calls == DEPTH) begin
				rep.overflow = 1'b1;
			end else begin
				if (act == ACT_PRIO) begin
					front_slot = front_slot - 1'b1;
					handler_slots[front_slot] = hid;
					param_slots[front_slot] = pval;
				end else begin
					handler_slots[back_slot] = hid;
					param_slots[back_slot] = pval;
					back_slot = back_slot + 1'b1;
				end
				held_calls = held_calls + 1'b1;
			end
		end else if (act == ACT_TAKE && held_calls != 0) begin
			rep.taken = 1'b1;
			rep.handler = handler_slots[front_slot];
			rep.param = param_slots[front_slot];
			front_slot = front_slot + 1'b1;
			held_calls = held_calls - 1'b1;
		end
		rep.occupancy = held_calls;
		return rep;
	endfunction

	always @(posedge clk) begin : check_replies
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_replies.size() == 0) begin
				$error("result item with no expectation waiting");
				failures++;
			end else begin
				want = expected_replies.pop_front();
				if (m_tuser !== want.taken) begin
					$error("taken: expected %0d, got %0d", want.taken, m_tuser);
					failures++;
				end
				if (m_tdata[15:0] !== want.handler) begin
					$error("out_handler: expected %h, got %h", want.handler, m_tdata[15:0]);
					failures++;
				end
				if (m_tdata[31:16] !== want.param) begin
					$error("out_param: expected %h, got %h", want.param, m_tdata[31:16]);
					failures++;
				end
				if (m_tdata[36:32] !== want.occupancy) begin
					$error("occupancy: expected %0d, got %0d", want.occupancy,
						m_tdata[36:32]);
					failures++;
				end
				if (m_tdata[37] !== want.overflow) begin
					$error("overflow: expected %0d, got %0d", want.overflow, m_tdata[37]);
					failures++;
				end
			end
		end
	end

	task automatic send_item(input logic [ACT_W-1:0] act, input logic [FIELD_W-1:0] hid,
			input logic [FIELD_W-1:0] pval);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= 32'($urandom);
			s_tuser <= 2'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {pval, hid};
		do @(posedge clk); while (!s_tready);
		expected_replies.push_back(serve_call_action(act, hid, pval));
	endtask

	task automatic test_empty_and_ignored();
		send_item(ACT_TAKE, 16'h1234, 16'h5678);
		send_item(ACT_NONE, 16'hFFFF, 16'hFFFF);
	endtask

	task automatic test_priority_order();
		send_item(ACT_POST, 16'hFFFF, 16'h0000);
		// front index wraps below zero
		send_item(ACT_PRIO, 16'h0000, 16'hFFFF);
		send_item(ACT_NONE, 16'hA5A5, 16'h5A5A);
		send_item(ACT_TAKE, 16'h0000, 16'h0000);
		send_item(ACT_TAKE, 16'hFFFF, 16'hFFFF);
	endtask

	task automatic test_full_queue();
		for (int i = 0; i < DEPTH; i++) begin
			send_item((i % 2) ? ACT_PRIO : ACT_POST, 16'($urandom), 16'($urandom));
		end
		send_item(ACT_POST, 16'hDEAD, 16'hBEEF);
		send_item(ACT_PRIO, 16'hBEEF, 16'hDEAD);
	endtask

	task automatic test_random_traffic(input int items, input int idle_pct,
			input int stall_pct);
		int post_share;
		int run_left;
		int r;
		logic [ACT_W-1:0] act;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		post_share = 70;
		run_left = 0;
		for (int i = 0; i < items; i++) begin
			// alternate filling and draining bursts so occupancy sweeps its range
			if (run_left == 0) begin
				run_left = $urandom_range(40, 12);
				post_share = (post_share > 50) ? 25 : 70;
			end
			run_left--;
			r = $urandom_range(99);
			if (r < 5)
				act = ACT_NONE;
			else if (r < 5 + post_share)
				act = $urandom_range(1) ? ACT_PRIO : ACT_POST;
			else
				act = ACT_TAKE;
			send_item(act, 16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_ignored();
		test_priority_order();
		test_full_queue();
		test_random_traffic(300, 0, 0);
		test_random_traffic(300, 83, 0);
		test_random_traffic(300, 0, 83);
		test_random_traffic(300, 22, 22);
		s_tvalid <= 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+design
design/pcrq_pkg.sv
design/pcrq_ram.sv
design/pcrq_ctrl.sv
design/priority_call_ring_queue_unit.sv
test/testbench.sv
